// ===== design/adcc_pkg.sv =====
// Shared types, widths and register codes for the ADC control conditioner.
package adcc_pkg;

	// Field widths
	localparam int RAW_W    = 24;
	localparam int OFFS_W   = 25;
	localparam int SCALE_W  = 16;
	localparam int COEFF_W  = 17;
	localparam int OUT_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 25;

	// Serial multiplier widths: multiplicand, multiplier, full product and bit counter
	localparam int MA_W   = 33;
	localparam int MB_W   = 17;
	localparam int PROD_W = MA_W + 1 + MB_W;
	localparam int CNT_W  = $clog2(MB_W);

	// Datapath widths
	localparam int T1_W  = 26;
	localparam int D_W   = 27;
	localparam int SUM_W = PROD_W - 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLIP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 3'd4;

	// Reset values and fixed-point constants
	localparam logic signed [SCALE_W-1:0] SCALE_RST = 16'sd4096;
	localparam logic [COEFF_W-1:0]        COEFF_ONE = 17'd65536;
	localparam logic signed [T1_W-1:0]    Q23_ONE   = 26'sd8388608;

	// Configuration register set
	typedef struct packed {
		logic                      flip;
		logic                      invert;
		logic signed [OFFS_W-1:0]  offset;
		logic signed [SCALE_W-1:0] scale;
		logic [COEFF_W-1:0]        coeff;
	} cfg_t;

endpackage

// ===== design/adcc_cfg_regs.sv =====
// Configuration register file with coefficient clamp.
module adcc_cfg_regs import adcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;
	logic [COEFF_W-1:0] coeff_clamped;

	// Values above unity are held at unity
	always_comb begin
		coeff_clamped = wr_data[COEFF_W-1:0];
		if (coeff_clamped > COEFF_ONE) begin
			coeff_clamped = COEFF_ONE;
		end
	end

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flip   <= 1'b0;
			cfg_q.invert <= 1'b0;
			cfg_q.offset <= '0;
			cfg_q.scale  <= SCALE_RST;
			cfg_q.coeff  <= COEFF_ONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_FLIP:   cfg_q.flip   <= wr_data[0];
				REG_INVERT: cfg_q.invert <= wr_data[0];
				REG_OFFSET: cfg_q.offset <= $signed(wr_data[OFFS_W-1:0]);
				REG_SCALE:  cfg_q.scale  <= $signed(wr_data[SCALE_W-1:0]);
				REG_COEFF:  cfg_q.coeff  <= coeff_clamped;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/adcc_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module adcc_serial_mul import adcc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MA_W-1:0]   a,
	input  logic [MB_W-1:0]          b,
	input  logic                     neg_msb,
	output logic                     done,
	output logic signed [PROD_W-1:0] prod
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [MA_W:0]  a_q;
	logic [MB_W-1:0]       b_q;
	logic                  negm_q;
	logic signed [MA_W:0]  hi_q;
	logic [MB_W-1:0]       lo_q;

	logic                  last;
	logic                  sub;
	logic signed [MA_W:0]  addend;
	logic signed [MA_W:0]  sum;

	// One partial product per cycle; the sign bit of a signed multiplier subtracts
	always_comb begin
		last   = (cnt_q == CNT_W'(MB_W - 1));
		sub    = last && negm_q && b_q[0];
		addend = '0;
		if (b_q[0]) begin
			addend = sub ? ~a_q : a_q;
		end
		sum = hi_q + addend + {{MA_W{1'b0}}, sub};
	end

	// Accumulator shifts right, low product bits collect in lo_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= {a[MA_W-1], a};
			b_q    <= b;
			negm_q <= neg_msb;
			hi_q   <= '0;
			lo_q   <= '0;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[MB_W-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// ===== design/adc_control_conditioner_unit.sv =====
// Top level: sample conditioning, one-pole smoothing and handshakes.
//
// Each accepted raw sample becomes one smoothed Q23 value. From acceptance an item
// passes through the offset step, the first multiply, the error step, the second
// multiply and the saturation step to the result register: both multiplies (offset
// sample by scale, then error by coefficient) run one after the other through a
// single bit-serial shift-add unit at one bit per cycle; the flip is applied at
// acceptance. A new item is taken only once the previous result has been loaded
// into the output register; that result may wait there while the next item is
// processed, and a stalled output holds the next result in the saturation step.
// Configuration writes are always ready and should be made while no item is in flight.
module adc_control_conditioner_unit import adcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RAW_W-1:0]     raw_sample,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [OUT_W-1:0] smoothed_value,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OFFS = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_ESUB = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_SAT  = 3'd5;

	cfg_t cfg;

	logic [2:0]                state_q;
	logic signed [T1_W-1:0]    t1_q;
	logic signed [MA_W-1:0]    s_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [OUT_W-1:0]   fv_q;
	logic signed [OUT_W-1:0]   out_q;
	logic                      out_valid_q;

	logic                      in_acc;
	logic                      out_load;
	logic                      mul_start;
	logic signed [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]           mul_b;
	logic                      mul_done;
	logic signed [PROD_W-1:0]  mul_prod;
	logic signed [T1_W-1:0]    raw_ext;
	logic signed [D_W-1:0]     d_val;
	logic signed [MA_W-1:0]    s_val;
	logic signed [SUM_W-1:0]   fv_ext;
	logic signed [OUT_W-1:0]   sat_val;

	assign cfg_ready = 1'b1;

	adcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_SAT) && (!out_valid_q || !out_stall);

	// Raw extension, offset term, scaled sample with invert and filter state extension
	always_comb begin
		raw_ext = $signed({{(T1_W-RAW_W){1'b0}}, raw_sample});
		d_val   = D_W'(t1_q) - D_W'(cfg.offset);
		s_val   = MA_W'(mul_prod[PROD_W-1:12]);
		if (cfg.invert) begin
			s_val = -s_val;
		end
		fv_ext = SUM_W'(fv_q);
	end

	// Multiplier operand select: scale pass then coefficient pass
	always_comb begin
		mul_start = (state_q == S_OFFS) || (state_q == S_ESUB);
		if (state_q == S_OFFS) begin
			mul_a = MA_W'(d_val);
			mul_b = MB_W'(cfg.scale);
		end else begin
			mul_a = s_q - MA_W'(fv_q);
			mul_b = cfg.coeff;
		end
	end

	adcc_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.neg_msb (state_q == S_OFFS),
		.done    (mul_done),
		.prod    (mul_prod)
	);

	// Clamp to the 32-bit signed range
	always_comb begin
		sat_val = sum_q[OUT_W-1:0];
		if (sum_q[SUM_W-1:OUT_W-1] != {(SUM_W-OUT_W+1){sum_q[SUM_W-1]}}) begin
			sat_val = sum_q[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_acc) state_q <= S_OFFS;
				S_OFFS: state_q <= S_MUL1;
				S_MUL1: if (mul_done) state_q <= S_ESUB;
				S_ESUB: state_q <= S_MUL2;
				S_MUL2: if (mul_done) state_q <= S_SAT;
				S_SAT:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t1_q <= cfg.flip ? (Q23_ONE - raw_ext) : raw_ext;
		end
		if ((state_q == S_MUL1) && mul_done) begin
			s_q <= s_val;
		end
		if ((state_q == S_MUL2) && mul_done) begin
			sum_q <= fv_ext + mul_prod[PROD_W-1:16];
		end
		if (out_load) begin
			out_q <= sat_val;
		end
	end

	// Filter state and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				fv_q        <= sat_val;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = out_q;

	// Checks
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL1 || state_q == S_MUL2))
		else $error("multiplier finished outside a multiply phase");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_OFFS))
		else $error("accepted item did not start processing");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && fv_q == out_q))
		else $error("result load did not update output and filter state together");

	a_coeff_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.coeff <= COEFF_ONE)
		else $error("smoothing coefficient above unity");

	a_fv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SAT) |=> $stable(fv_q))
		else $error("filter state changed outside the update step");

endmodule
